// ===== design/assert_macros.svh =====
// Assertion macros shared by the tone period converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define PTP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/ptp_pkg.sv =====
// Types and constants of the pitch to tone period converter.
package ptp_pkg;

  // Octave period table geometry
  localparam int unsigned ROM_DEPTH = 768;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  localparam int unsigned ROM_DW    = 16;

  localparam logic [ROM_AW-1:0] ROM_LAST      = ROM_AW'(ROM_DEPTH - 1);
  localparam logic [ROM_AW-1:0] ROM_LAST_EVEN = ROM_AW'(ROM_DEPTH - 2);
  localparam logic [ROM_DW-1:0] ROM_SEED      = 16'd34323;
  localparam logic [31:0]       ROUND_HALF    = 32'h0000_8000;

  // Scale factors (16-bit fractions) per fill stage, last one for the top entry
  localparam logic [ROM_DW-1:0] ROM_STEP [9] = '{
    16'd52016, 16'd58386, 16'd61858, 16'd63670, 16'd64596,
    16'd65065, 16'd65300, 16'd65418, 16'd65477
  };

  // Pitch limits and octave split: floor(x / 3) as (x * 171) >> 9 for x < 512
  localparam logic signed [14:0] PITCH_MIN       = 15'sd1588;
  localparam logic [13:0]        OCT_RECIP       = 14'd171;
  localparam int unsigned        OCT_RECIP_SHIFT = 9;

  localparam logic [15:0] PERIOD_LOW = 16'h0FFF;

  // Period correction modes, from distortion bits 5-4
  localparam logic [1:0] CORR_POLY  = 2'b01;
  localparam logic [1:0] CORR_MOD31 = 2'b10;
  localparam logic [4:0] MOD31_HIT  = 5'd30;

  // Poly4 corrections by residue, table selected by channel distortion bit 3
  localparam logic signed [2:0] POLY_FIX_A [16] = '{
    3'sd2, 3'sd1, 3'sd0, -3'sd1, 3'sd1, 3'sd0, -3'sd1, 3'sd1,
    3'sd0, -3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd2, 3'sd3, 3'sd2
  };
  localparam logic signed [2:0] POLY_FIX_B [16] = '{
    3'sd0, 3'sd0, -3'sd1, 3'sd0, -3'sd1, 3'sd1, 3'sd0, 3'sd0,
    -3'sd1, 3'sd1, 3'sd0, 3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd0
  };

  // Per-item side information carried down the pipeline
  typedef struct packed {
    logic       noise;
    logic       low;
    logic       poly_a;
    logic [3:0] shift;
    logic [7:0] dbyte;
  } ptp_side_t;

endpackage

// ===== design/ptp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/ptp_rom_fill.sv =====
// Sequencer that builds the octave period table in RAM after reset.
`include "assert_macros.svh"

module ptp_rom_fill (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [ptp_pkg::ROM_AW-1:0]  rd_addr_o,
  input  logic [ptp_pkg::ROM_DW-1:0]  rd_data_i,
  output logic                        wr_en_o,
  output logic [ptp_pkg::ROM_AW-1:0]  wr_addr_o,
  output logic [ptp_pkg::ROM_DW-1:0]  wr_data_o
);

  typedef enum logic [4:0] {
    FILL_RD_A = 5'b00001,
    FILL_RD_B = 5'b00010,
    FILL_CALC = 5'b00100,
    FILL_WR   = 5'b01000,
    FILL_DONE = 5'b10000
  } fill_state_e;

  fill_state_e                 state_q, state_d;
  logic [ptp_pkg::ROM_AW-1:0]  idx_q, idx_d;
  logic [ptp_pkg::ROM_DW-1:0]  a_q;
  logic [ptp_pkg::ROM_DW-1:0]  mid_q;
  logic [2*ptp_pkg::ROM_DW-1:0] prod_q;
  logic [2*ptp_pkg::ROM_DW-1:0] rounded;
  logic [3:0]                  low_zeros;
  logic [3:0]                  step_sel;
  logic [ptp_pkg::ROM_AW-1:0]  src_addr;
  logic                        is_seed;
  logic                        is_interp;

  // Trailing zero count of the entry index, capped at 8 (one 256-entry step)
  function automatic logic [3:0] trailing_zeros(input logic [ptp_pkg::ROM_AW-1:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (v[k]) begin
        n = 4'(k);
      end
    end
    return n;
  endfunction

  // Entry classification: evens scale a coarser entry, odds interpolate,
  // the top entry scales its lower neighbor with the finest factor
  assign low_zeros = trailing_zeros(idx_q);
  assign step_sel  = 4'd8 - low_zeros;
  assign src_addr  = idx_q - (ptp_pkg::ROM_AW'(1) << low_zeros);
  assign is_seed   = (idx_q == '0);
  assign is_interp = idx_q[0] && (idx_q != ptp_pkg::ROM_LAST);
  assign rounded   = prod_q + ptp_pkg::ROUND_HALF;

  // RAM access
  always_comb begin
    rd_en_o   = (state_q == FILL_RD_A) || (state_q == FILL_RD_B);
    rd_addr_o = is_seed ? '0 : src_addr;
    if ((state_q == FILL_RD_B) && is_interp) begin
      rd_addr_o = idx_q + ptp_pkg::ROM_AW'(1);
    end
    wr_en_o   = (state_q == FILL_WR);
    wr_addr_o = idx_q;
    if (is_seed) begin
      wr_data_o = ptp_pkg::ROM_SEED;
    end else if (is_interp) begin
      wr_data_o = mid_q;
    end else begin
      wr_data_o = rounded[31:16];
    end
  end

  // Sequencer: evens in ascending order, then odds
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      FILL_RD_A: state_d = FILL_RD_B;
      FILL_RD_B: state_d = FILL_CALC;
      FILL_CALC: state_d = FILL_WR;
      FILL_WR: begin
        if (idx_q == ptp_pkg::ROM_LAST) begin
          state_d = FILL_DONE;
        end else begin
          state_d = FILL_RD_A;
          idx_d   = (idx_q == ptp_pkg::ROM_LAST_EVEN) ? ptp_pkg::ROM_AW'(1)
                                                      : idx_q + ptp_pkg::ROM_AW'(2);
        end
      end
      FILL_DONE: state_d = FILL_DONE;
      default:   state_d = FILL_RD_A;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL_RD_A;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Operand capture, scale product and neighbor average
  always_ff @(posedge clk_i) begin
    if (state_q == FILL_RD_B) begin
      a_q <= rd_data_i;
    end
    if (state_q == FILL_CALC) begin
      prod_q <= a_q * ptp_pkg::ROM_STEP[step_sel];
      mid_q  <= (a_q >> 1) + (rd_data_i >> 1)
              + {15'b0, a_q[0] | rd_data_i[0]};
    end
  end

  assign busy_o = (state_q != FILL_DONE);

  `PTP_ASSERT(a_fill_wr_range, wr_en_o |-> wr_addr_o <= ptp_pkg::ROM_LAST, "fill write past table end")
  `PTP_ASSERT(a_fill_done_sticky, !busy_o |=> !busy_o, "table fill restarted after completion")

endmodule

// ===== design/ptp_front.sv =====
// Front pipeline: pitch sum, octave split and table address (stages 1 to 3).
`include "assert_macros.svh"

module ptp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fill_busy_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       is_noise_channel_i,
  input  logic [15:0]                note_pitch_i,
  input  logic [15:0]                envelope_word_i,
  input  logic [7:0]                 channel_distortion_i,
  input  logic                       s4_ready_i,
  output logic                       rd_en_o,
  output logic [ptp_pkg::ROM_AW-1:0] rd_addr_o,
  output logic                       s3_valid_o,
  output ptp_pkg::ptp_side_t         s3_side_o
);

  logic                v1_q, v2_q, v3_q;
  logic                rdy1, rdy2, rdy3;
  logic                accept;
  logic signed [14:0]  pitch_d;
  logic signed [14:0]  s1_pitch_q;
  ptp_pkg::ptp_side_t  side_d, s1_side_q;
  ptp_pkg::ptp_side_t  s2_side_d, s2_side_q;
  ptp_pkg::ptp_side_t  s3_side_q;
  logic [13:0]         s2_pitch_q;
  logic [13:0]         oct_prod;
  logic [13:0]         oct_base;
  logic [13:0]         rom_index;

  // Stage enables: a stage loads when empty or when the next one moves
  assign rdy3       = !v3_q || s4_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign accept     = in_valid_i && rdy1 && !fill_busy_i;
  assign in_stall_o = !rdy1 || fill_busy_i;

  // Stage 1: pitch in 1/64 semitones plus signed envelope offset
  always_comb begin
    pitch_d = $signed({2'b00, note_pitch_i[14:8], 6'b000000})
            + $signed({7'b0000000, note_pitch_i[7:0]})
            + $signed({{3{envelope_word_i[11]}}, envelope_word_i[11:0]});
    side_d        = '0;
    side_d.noise  = is_noise_channel_i;
    side_d.poly_a = channel_distortion_i[3];
    side_d.dbyte  = envelope_word_i[15:8] ^ channel_distortion_i;
  end

  // Stage 2: low pitch flag and octave count floor(pitch / 768)
  always_comb begin
    oct_prod        = 14'(s1_pitch_q[13:8]) * ptp_pkg::OCT_RECIP;
    s2_side_d       = s1_side_q;
    s2_side_d.low   = (s1_pitch_q < ptp_pkg::PITCH_MIN);
    s2_side_d.shift = 4'(oct_prod >> ptp_pkg::OCT_RECIP_SHIFT);
  end

  // Stage 3 address: remainder within the octave
  assign oct_base  = {1'b0, s2_side_q.shift, 9'b0} + {2'b00, s2_side_q.shift, 8'b0};
  assign rom_index = s2_pitch_q - oct_base;
  assign rd_addr_o = s2_side_q.low ? '0 : rom_index[ptp_pkg::ROM_AW-1:0];
  assign rd_en_o   = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_pitch_q <= pitch_d;
      s1_side_q  <= side_d;
    end
    if (rdy2 && v1_q) begin
      s2_pitch_q <= s1_pitch_q[13:0];
      s2_side_q  <= s2_side_d;
    end
    if (rdy3 && v2_q) begin
      s3_side_q <= s2_side_q;
    end
  end

  assign s3_valid_o = v3_q;
  assign s3_side_o  = s3_side_q;

  `PTP_ASSERT(a_front_index_range, v2_q && !s2_side_q.low |-> rom_index < 14'(ptp_pkg::ROM_DEPTH), "octave split left table index out of range")

endmodule

// ===== design/ptp_back.sv =====
// Back pipeline: period from table word, correction, output word (stages 4 to 6).
`include "assert_macros.svh"

module ptp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s3_valid_i,
  input  ptp_pkg::ptp_side_t         s3_side_i,
  input  logic [ptp_pkg::ROM_DW-1:0] rom_data_i,
  output logic                       s4_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                tone_word_o
);

  logic               v4_q, v5_q, v6_q;
  logic               rdy4, rdy5, rdy6;
  logic [15:0]        shifted;
  logic [15:0]        dec;
  logic [15:0]        per_d;
  logic [15:0]        s4_per_q;
  ptp_pkg::ptp_side_t s4_side_q;
  logic [5:0]         nib_sum;
  logic [4:0]         nib_fold;
  logic [3:0]         poly_m;
  logic [8:0]         m31_a;
  logic [5:0]         m31_b;
  logic [4:0]         m31_c;
  logic signed [2:0]  corr_d;
  logic signed [2:0]  s5_corr_q;
  logic [15:0]        s5_per_q;
  ptp_pkg::ptp_side_t s5_side_q;
  logic [15:0]        tone_d;
  logic [15:0]        tone_q;

  // Stage enables; the output register frees as soon as its item is taken
  assign rdy6       = !v6_q || !out_stall_i;
  assign rdy5       = !v5_q || rdy6;
  assign rdy4       = !v4_q || rdy5;
  assign s4_ready_o = rdy4;

  // Stage 4: octave shift, then (value - 1) / 2 with 16-bit wrap
  always_comb begin
    shifted = rom_data_i >> s3_side_i.shift;
    dec     = shifted - 16'd1;
    per_d   = s3_side_i.low ? ptp_pkg::PERIOD_LOW : {1'b0, dec[15:1]};
  end

  // Stage 5: residues and correction
  always_comb begin
    // nibble digital root: residue mod 15, zero only for a zero period
    nib_sum  = 6'(s4_per_q[3:0]) + 6'(s4_per_q[7:4])
             + 6'(s4_per_q[11:8]) + 6'(s4_per_q[15:12]);
    nib_fold = 5'(nib_sum[3:0]) + 5'(nib_sum[5:4]);
    poly_m   = (nib_fold > 5'd15) ? nib_fold[3:0] + 4'(nib_fold[4]) : nib_fold[3:0];

    // 5-bit fold; the first step drops period bits 15-13
    m31_a = (s4_per_q > 16'd31) ? 9'(s4_per_q[4:0]) + 9'(s4_per_q[12:5])
                                : s4_per_q[8:0];
    m31_b = (m31_a > 9'd31) ? 6'(m31_a[4:0]) + 6'(m31_a[8:5]) : m31_a[5:0];
    m31_c = (m31_b > 6'd31) ? m31_b[4:0] + 5'(m31_b[5]) : m31_b[4:0];

    case (s4_side_q.dbyte[5:4])
      ptp_pkg::CORR_POLY: begin
        corr_d = s4_side_q.poly_a ? ptp_pkg::POLY_FIX_A[poly_m]
                                  : ptp_pkg::POLY_FIX_B[poly_m];
      end
      ptp_pkg::CORR_MOD31: begin
        corr_d = (m31_c == ptp_pkg::MOD31_HIT) ? 3'sd1 : 3'sd0;
      end
      default: corr_d = 3'sd0;
    endcase
  end

  // Stage 6: output word; noise channel carries only the distortion byte
  always_comb begin
    if (s5_side_q.noise) begin
      tone_d = {8'h00, s5_side_q.dbyte};
    end else begin
      tone_d = (s5_per_q + {{13{s5_corr_q[2]}}, s5_corr_q})
             | {s5_side_q.dbyte[7:4], 12'h000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= s3_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_valid_i) begin
      s4_per_q  <= per_d;
      s4_side_q <= s3_side_i;
    end
    if (rdy5 && v4_q) begin
      s5_per_q  <= s4_per_q;
      s5_corr_q <= corr_d;
      s5_side_q <= s4_side_q;
    end
    if (rdy6 && v5_q) begin
      tone_q <= tone_d;
    end
  end

  assign out_valid_o = v6_q;
  assign tone_word_o = tone_q;

  `PTP_ASSERT(a_back_poly_zero, v4_q |-> ((poly_m == 4'd0) == (s4_per_q == 16'd0)), "poly residue zero-ness disagrees with period")
  `PTP_ASSERT_NEVER(a_back_corr_mode, v5_q && (s5_corr_q != 3'sd0) && (s5_side_q.dbyte[5:4] != ptp_pkg::CORR_POLY) && (s5_side_q.dbyte[5:4] != ptp_pkg::CORR_MOD31), "correction applied outside a correction mode")

endmodule

// ===== design/pitch_to_tone_period.sv =====
// Top level of the pitch to tone period converter.
// Converts one channel per clock unless stalled: note pitch plus envelope
// offset becomes a 12-bit tone period with the distortion nibble in bits
// 15-12 (noise channel: the distortion byte alone). Throughput is one item
// per cycle unless out_stall_i or the table fill stalls; out_valid_o rises
// once an item has passed the six register stages (the first loads at the
// accepting edge) around the registered read of the 768-entry octave period
// table. After reset a fill sequencer builds the table in RAM (two reads, a
// calculation and a write per entry); in_stall_o stays high until it is done.
module pitch_to_tone_period (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_noise_channel_i,
  input  logic [15:0] note_pitch_i,
  input  logic [15:0] envelope_word_i,
  input  logic [7:0]  channel_distortion_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] tone_word_o
);

  logic                       fill_busy;
  logic                       fill_rd_en;
  logic [ptp_pkg::ROM_AW-1:0] fill_rd_addr;
  logic                       fill_wr_en;
  logic [ptp_pkg::ROM_AW-1:0] fill_wr_addr;
  logic [ptp_pkg::ROM_DW-1:0] fill_wr_data;
  logic                       front_rd_en;
  logic [ptp_pkg::ROM_AW-1:0] front_rd_addr;
  logic                       ram_rd_en;
  logic [ptp_pkg::ROM_AW-1:0] ram_rd_addr;
  logic [ptp_pkg::ROM_DW-1:0] ram_rd_data;
  logic                       s3_valid;
  ptp_pkg::ptp_side_t         s3_side;
  logic                       s4_ready;

  // Table build after reset
  ptp_rom_fill u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (fill_busy),
    .rd_en_o   (fill_rd_en),
    .rd_addr_o (fill_rd_addr),
    .rd_data_i (ram_rd_data),
    .wr_en_o   (fill_wr_en),
    .wr_addr_o (fill_wr_addr),
    .wr_data_o (fill_wr_data)
  );

  // Read port belongs to the fill sequencer until the table is complete
  assign ram_rd_en   = fill_busy ? fill_rd_en   : front_rd_en;
  assign ram_rd_addr = fill_busy ? fill_rd_addr : front_rd_addr;

  ptp_ram #(
    .WIDTH (ptp_pkg::ROM_DW),
    .DEPTH (ptp_pkg::ROM_DEPTH)
  ) u_rom (
    .clk_i     (clk_i),
    .wr_en_i   (fill_wr_en),
    .wr_addr_i (fill_wr_addr),
    .wr_data_i (fill_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  ptp_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .fill_busy_i          (fill_busy),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .is_noise_channel_i   (is_noise_channel_i),
    .note_pitch_i         (note_pitch_i),
    .envelope_word_i      (envelope_word_i),
    .channel_distortion_i (channel_distortion_i),
    .s4_ready_i           (s4_ready),
    .rd_en_o              (front_rd_en),
    .rd_addr_o            (front_rd_addr),
    .s3_valid_o           (s3_valid),
    .s3_side_o            (s3_side)
  );

  ptp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s3_valid_i  (s3_valid),
    .s3_side_i   (s3_side),
    .rom_data_i  (ram_rd_data),
    .s4_ready_o  (s4_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tone_word_o (tone_word_o)
  );

endmodule

// ===== sim/pitch_to_tone_period_test.sv =====
// Testbench for the pitch to tone period converter: directed table, random items, own predictor.
module pitch_to_tone_period_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOW_PITCH   = 1588;
  localparam int TAB_DEPTH   = 768;
  localparam int HOLD_CYCLES = 200;
  localparam int N_RANDOM    = 1000;

  // One channel conversion request
  typedef struct packed {
    logic        noise;
    logic [15:0] note_pitch;
    logic [15:0] env_word;
    logic [7:0]  chan_dist;
  } tone_req_t;

  // Directed row: request plus a hand-written tone word where it is obvious
  typedef struct packed {
    tone_req_t   req;
    logic        typed;
    logic [15:0] tone;
  } tone_case_t;

  localparam tone_case_t DIR_TAB [23] = '{
    // noise channel: XOR byte only
    '{'{1'b1, 16'h0000, 16'h0000, 8'h00}, 1'b1, 16'h0000},
    '{'{1'b1, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, 16'h0000},
    '{'{1'b1, 16'h1234, 16'hA500, 8'h5A}, 1'b1, 16'h00FF},
    // pitch too low or negative
    '{'{1'b0, 16'h0000, 16'h0000, 8'h00}, 1'b1, 16'h0FFF},
    '{'{1'b0, 16'h1833, 16'h0000, 8'hC0}, 1'b1, 16'hCFFF},
    '{'{1'b0, 16'h0000, 16'h0800, 8'h00}, 1'b1, 16'h0FFF},
    '{'{1'b0, 16'h8000, 16'h4000, 8'h80}, 1'b1, 16'hCFFF},
    '{'{1'b0, 16'h1834, 16'h0FFF, 8'h00}, 1'b1, 16'h0FFF},
    // lowest valid pitch, offset extremes, top of range
    '{'{1'b0, 16'h1834, 16'h0000, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h0000, 16'h07FF, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h7FFF, 16'h07FF, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'hFFFF, 16'hF7FF, 8'hFF}, 1'b0, 16'h0000},
    // octave boundaries
    '{'{1'b0, 16'h5F3F, 16'h0000, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h6000, 16'h0000, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h2F3F, 16'h0000, 8'h00}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h3000, 16'h0000, 8'h00}, 1'b0, 16'h0000},
    // poly4 corrections, both tables, also on the low-pitch period
    '{'{1'b0, 16'h3000, 16'h0000, 8'h18}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h3000, 16'h0000, 8'h10}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h0000, 16'h0000, 8'h18}, 1'b0, 16'h0000},
    // mod-31 fold, mode set by channel byte or by envelope byte
    '{'{1'b0, 16'h4523, 16'h0000, 8'h20}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h0000, 16'h2000, 8'h00}, 1'b0, 16'h0000},
    // mode 3: no correction; then mixed bytes with a positive offset
    '{'{1'b0, 16'h3000, 16'h0000, 8'h30}, 1'b0, 16'h0000},
    '{'{1'b0, 16'h2A17, 16'hF123, 8'hE7}, 1'b0, 16'h0000}
  };

  localparam int POLY_A [16] = '{2, 1, 0, -1, 1, 0, -1, 1, 0, -1, 1, 0, -1, -2, 3, 2};
  localparam int POLY_B [16] = '{0, 0, -1, 0, -1, 1, 0, 0, -1, 1, 0, 1, 0, 0, 1, 0};
  localparam logic [15:0] FILL_STEP [9] = '{
    16'd52016, 16'd58386, 16'd61858, 16'd63670, 16'd64596,
    16'd65065, 16'd65300, 16'd65418, 16'd65477
  };

  logic        clk_i                = 1'b0;
  logic        rst_ni               = 1'b0;
  logic        in_valid_i           = 1'b0;
  logic        in_stall_o;
  logic        is_noise_channel_i   = 1'b0;
  logic [15:0] note_pitch_i         = 16'h0000;
  logic [15:0] envelope_word_i      = 16'h0000;
  logic [7:0]  channel_distortion_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i          = 1'b0;
  logic [15:0] tone_word_o;

  logic [15:0] period_tab [TAB_DEPTH];
  logic [15:0] tone_q [$];
  logic [15:0] want_tone;

  bit          idle_on    = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned stall_left = 0;
  int          n_sent, n_checked, n_fail, n_noise, n_low, n_poly, n_mod31_hit;

  pitch_to_tone_period uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .is_noise_channel_i   (is_noise_channel_i),
    .note_pitch_i         (note_pitch_i),
    .envelope_word_i      (envelope_word_i),
    .channel_distortion_i (channel_distortion_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .tone_word_o          (tone_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded 16-bit fractional scaling
  function automatic logic [15:0] scaled(logic [15:0] v, logic [15:0] f);
    logic [32:0] prod;
    prod = 33'(v) * 33'(f) + 33'h0_8000;
    return prod[31:16];
  endfunction

  // Geometric fill by halving steps, then odd entries as midpoints and the top entry scaled
  function automatic void build_period_tab();
    int step;
    logic [15:0] a, b;
    foreach (period_tab[i]) period_tab[i] = 16'h0000;
    period_tab[0] = 16'd34323;
    for (int s = 0; s < 8; s++) begin
      step = 256 >> s;
      for (int j = step; j < TAB_DEPTH; j += step) begin
        if (period_tab[j] == 16'h0000) period_tab[j] = scaled(period_tab[j - step], FILL_STEP[s]);
      end
    end
    for (int j = 1; j < TAB_DEPTH - 1; j += 2) begin
      a = period_tab[j - 1];
      b = period_tab[j + 1];
      period_tab[j] = (a >> 1) + (b >> 1) + 16'((a | b) & 16'h0001);
    end
    period_tab[TAB_DEPTH - 1] = scaled(period_tab[TAB_DEPTH - 2], FILL_STEP[8]);
  endfunction

  // Expected tone word for one request
  function automatic logic [15:0] tone_word_of(tone_req_t r);
    logic [7:0]  dbyte;
    logic [15:0] per, raw;
    int          pitch, q, sh;
    int unsigned n, m;
    dbyte = r.env_word[15:8] ^ r.chan_dist;
    if (r.noise) return {8'h00, dbyte};
    pitch = int'(r.note_pitch[14:8]) * 64 + int'(r.note_pitch[7:0])
          + int'($signed(r.env_word[11:0]));
    if (pitch < LOW_PITCH || pitch >= 32768) begin
      per = ptp_pkg::PERIOD_LOW;
      n_low++;
    end else begin
      // octave split: shift of 8, 4, 2, 1 per folded range
      q  = pitch;
      sh = 0;
      if (q >= 'h1800) begin q -= 'h1800; sh += 8; end
      if (q >= 'h0C00) begin q -= 'h0C00; sh += 4; end
      if (q >= 'h0600) begin q -= 'h0600; sh += 2; end
      if (q >= 'h0300) begin q -= 'h0300; sh += 1; end
      if (q >= TAB_DEPTH) q = TAB_DEPTH - 1;
      raw = period_tab[q] >> sh;
      raw = raw - 16'd1;
      per = raw >> 1;
    end
    if (dbyte[5:4] == ptp_pkg::CORR_POLY) begin
      // residue mod 15 via byte then nibble folding
      n = per;
      while (n >= 256) n = (n & 255) + (n >> 8);
      m = n;
      while (m > 15) m = (m & 15) + (m >> 4);
      per = per + 16'(r.chan_dist[3] ? POLY_A[m] : POLY_B[m]);
      n_poly++;
    end else if (dbyte[5:4] == ptp_pkg::CORR_MOD31) begin
      m = per;
      while (m > 31) m = (m & 31) + (((m << 3) & 32'hFFFF) >> 8);
      if (m == ptp_pkg::MOD31_HIT) begin
        per = per + 16'd1;
        n_mod31_hit++;
      end
    end
    return per | {dbyte[7:4], 12'h000};
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Most requests carry a note in the convertible range
  function automatic tone_req_t random_req();
    tone_req_t r;
    r.noise = ($urandom_range(0, 99) < 12);
    if ($urandom_range(0, 3) == 0) r.note_pitch = 16'($urandom);
    else r.note_pitch = {1'($urandom_range(0, 1)), 7'($urandom_range(25, 127)), 8'($urandom)};
    r.env_word  = 16'($urandom);
    r.chan_dist = 8'($urandom);
    return r;
  endfunction

  // Present one item and wait for it to be taken
  task automatic offer(input tone_req_t r, input logic typed, input logic [15:0] tone);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    is_noise_channel_i   <= r.noise;
    note_pitch_i         <= r.note_pitch;
    envelope_word_i      <= r.env_word;
    channel_distortion_i <= r.chan_dist;
    do @(posedge clk_i); while (in_stall_o);
    tone_q.push_back(typed ? tone : tone_word_of(r));
    n_sent++;
    if (r.noise) n_noise++;
  endtask

  // Result side: compare each taken item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tone_q.size() == 0) begin
        $error("tone_word: unexpected result %h", tone_word_o);
        n_fail++;
      end else begin
        want_tone = tone_q.pop_front();
        n_checked++;
        if (tone_word_o !== want_tone) begin
          $error("tone_word: expected %h, got %h", want_tone, tone_word_o);
          n_fail++;
        end
      end
    end
  end

  // Receiver stalls: random bursts, or one long hold on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      out_stall_i <= 1'b1;
      stall_left  = HOLD_CYCLES - 1;
    end else if (idle_on) begin
      stall_left  = pick_gap();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    build_period_tab();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, back to back
    foreach (DIR_TAB[i]) offer(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].tone);
    in_valid_i <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk_i);

    // long receiver hold while items keep coming, so the input backs up
    hold_req = 1'b1;
    repeat (60) offer(random_req(), 1'b0, 16'h0000);

    // random items, idling switched on and off in stretches
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 125 == 0) idle_on = ((k / 125) % 3 != 2);
      offer(random_req(), 1'b0, 16'h0000);
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b0;

    while (tone_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("Converted %0d items, %0d results checked, %0d noise channel",
             n_sent, n_checked, n_noise);
    $display("Low pitch %0d, poly4 corrected %0d, mod-31 bumps %0d",
             n_low, n_poly, n_mod31_hit);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ptp_pkg.sv
design/ptp_ram.sv
design/ptp_rom_fill.sv
design/ptp_front.sv
design/ptp_back.sv
design/pitch_to_tone_period.sv
sim/pitch_to_tone_period_test.sv
